### sv/tccs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_pkg: shared definitions for the text console engine
// Command codes, control byte values, stream field layout and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tccs_pkg;

	// Command codes carried on s_tuser
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Control bytes and printable range
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// Attribute used by the power-up clearing pass
	localparam logic [7:0] RESET_ATTR = 8'h0F;

	// Field widths
	localparam int OPC_W  = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int OCOL_W = 7;
	localparam int OROW_W = 5;
	localparam int OLOC_W = 11;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;

	// Stream widths (whole bytes)
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 40;

	// Result field positions in m_tdata
	localparam int M_COL_LSB  = 0;
	localparam int M_ROW_LSB  = M_COL_LSB + OCOL_W;
	localparam int M_LOC_LSB  = M_ROW_LSB + OROW_W;
	localparam int M_CELL_LSB = M_LOC_LSB + OLOC_W;
	localparam int M_SCR_BIT  = M_CELL_LSB + CELL_W;

	// Controller to datapath
	typedef struct packed {
		logic accept;      // input transfer this cycle
		logic sweep;       // step the cell sweep counter
		logic sweep_copy;  // sweep moves lines up (scroll)
		logic sweep_init;  // sweep uses the power-up attribute
		logic load_out;    // load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_last;  // counter on the last cell
		logic wr_busy;     // a cell write is still in flight
		logic out_free;    // result register can take a new result
		logic op_clear;    // offered command is a clear
		logic need_scroll; // offered command scrolls the screen
	} sts_t;

endpackage : tccs_pkg
`default_nettype wire

### sv/tccs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_ctrl: command sequencer
// Accepts one command at a time, runs the clear and scroll sweeps and the
// power-up clearing pass, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tccs_ctrl
	import tccs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  sts_t      sts,
	output cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_INIT   = 5'b00001,
		S_IDLE   = 5'b00010,
		S_CLEAR  = 5'b00100,
		S_SCROLL = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Input is taken only when idle and the last cell write has landed
	assign s_tready = (state_q == S_IDLE) && !sts.wr_busy;

	// Commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.accept     = s_tready && s_tvalid;
		cmd.sweep      = (state_q == S_INIT) || (state_q == S_CLEAR) ||
		                 (state_q == S_SCROLL);
		cmd.sweep_copy = (state_q == S_SCROLL);
		cmd.sweep_init = (state_q == S_INIT);
		cmd.load_out   = (state_q == S_RESP) && sts.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd.accept) begin
					if (sts.op_clear)         state_d = S_CLEAR;
					else if (sts.need_scroll) state_d = S_SCROLL;
					else                      state_d = S_RESP;
				end
			end
			S_CLEAR, S_SCROLL: begin
				if (sts.sweep_last) state_d = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule : tccs_ctrl
`default_nettype wire

### sv/tccs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_dp: console datapath
// Cell buffer, cursor, attribute register, sweep counter, delayed write
// stage and the result register.
// ----------------------------------------------------------------------------
module tccs_dp
	import tccs_pkg::*;
#(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	// offered command
	input  wire logic [OPC_W-1:0]  opcode,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [IDX_W-1:0]  cell_index,
	// attribute register write
	input  wire logic              cfg_valid,
	input  wire logic [ATTR_W-1:0] cfg_data,
	// result
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [OCOL_W-1:0]      cursor_col,
	output logic [OROW_W-1:0]      cursor_row,
	output logic [OLOC_W-1:0]      cursor_addr,
	output logic [CELL_W-1:0]      cell_data,
	output logic                   scrolled
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CIDX_W     = $clog2(COLUMNS);
	localparam int RIDX_W     = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W      = $clog2(ROWS + 1);
	localparam int CMP_W      = ADDR_W + IDX_W + 1;
	localparam int TAB_DEPTH  = 2 ** CIDX_W;

	// Registers
	logic [ATTR_W-1:0] attr_q;
	logic [CIDX_W-1:0] cur_col_q;
	logic [RIDX_W-1:0] cur_row_q;
	logic [ADDR_W-1:0] sweep_cnt_q;
	logic              scrolled_q;
	logic              cell_sel_q;
	logic [CELL_W-1:0] cells_q [CELL_COUNT];
	logic [CELL_W-1:0] rd_data_q;
	logic              wr_pend_s1;
	logic              wr_copy_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic [CELL_W-1:0] wr_data_s1;
	logic              out_valid_q;
	logic [OCOL_W-1:0] out_col_q;
	logic [OROW_W-1:0] out_row_q;
	logic [OLOC_W-1:0] out_loc_q;
	logic [CELL_W-1:0] out_cell_q;
	logic              out_scr_q;

	// Next tab stop for each column, worked out at elaboration
	logic [COL_W-1:0] tab_next [TAB_DEPTH];
	for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_tab
		assign tab_next[i] = COL_W'(i + TAB_STOP - (i % TAB_STOP));
	end

	// Linear location of the cursor
	logic [ADDR_W-1:0] cur_loc;
	assign cur_loc = ADDR_W'(cur_row_q * COLUMNS) + ADDR_W'(cur_col_q);

	// Command decode
	logic is_put, is_read, printable, read_ok;
	assign is_put    = (opcode == OP_PUT);
	assign is_read   = (opcode == OP_READ);
	assign printable = char_code inside {[CH_SPACE:CH_DEL]};
	assign read_ok   = CMP_W'(cell_index) < CMP_W'(CELL_COUNT);

	// Cursor movement for put character, with wrap and scroll
	logic [COL_W-1:0]  col_a;
	logic [ROW_W-1:0]  row_a;
	logic              scroll_n;
	logic [CIDX_W-1:0] col_n;
	logic [RIDX_W-1:0] row_n;

	always_comb begin
		col_a = COL_W'(cur_col_q);
		row_a = ROW_W'(cur_row_q);
		case (char_code)
			CH_BS: begin
				if (col_a != '0) col_a = col_a - COL_W'(1);
			end
			CH_TAB: col_a = tab_next[cur_col_q];
			CH_CR:  col_a = '0;
			CH_LF: begin
				col_a = '0;
				row_a = row_a + ROW_W'(1);
			end
			default: begin
				if (printable) col_a = col_a + COL_W'(1);
			end
		endcase
		if (col_a >= COL_W'(COLUMNS)) begin
			col_a = '0;
			row_a = row_a + ROW_W'(1);
		end
		scroll_n = (row_a >= ROW_W'(ROWS));
		col_n    = col_a[CIDX_W-1:0];
		row_n    = scroll_n ? RIDX_W'(ROWS - 1) : row_a[RIDX_W-1:0];
	end

	// Sweep step: copy from one line below while in the upper rows
	logic sweep_last, sweep_rd;
	logic [ATTR_W-1:0] sweep_attr;
	assign sweep_last = (sweep_cnt_q == ADDR_W'(CELL_COUNT - 1));
	assign sweep_rd   = cmd.sweep_copy && (sweep_cnt_q < ADDR_W'(CELL_COUNT - COLUMNS));
	assign sweep_attr = cmd.sweep_init ? RESET_ATTR : attr_q;

	// Read port control
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	assign rd_en   = (cmd.sweep && sweep_rd) || (cmd.accept && is_read && read_ok);
	assign rd_addr = cmd.sweep ? (sweep_cnt_q + ADDR_W'(COLUMNS)) : ADDR_W'(cell_index);

	// Status to the controller
	always_comb begin
		sts             = '0;
		sts.sweep_last  = sweep_last;
		sts.wr_busy     = wr_pend_s1;
		sts.out_free    = !out_valid_q || out_ready;
		sts.op_clear    = (opcode == OP_CLEAR);
		sts.need_scroll = is_put && scroll_n;
	end

	// Attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_valid) begin
			attr_q <= cfg_data;
		end
	end

	// Cursor and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			sweep_cnt_q <= '0;
		end else begin
			if (cmd.accept && is_put) begin
				cur_col_q <= col_n;
				cur_row_q <= row_n;
			end else if (cmd.accept && sts.op_clear) begin
				cur_col_q <= '0;
				cur_row_q <= '0;
			end
			if (cmd.sweep) begin
				sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + ADDR_W'(1);
			end
		end
	end

	// Per-command result flags
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			scrolled_q <= is_put && scroll_n;
			cell_sel_q <= is_read && read_ok;
		end
	end

	// Delayed write stage: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.sweep || (cmd.accept && is_put && printable);
		end
	end

	// Delayed write stage: address and data
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			wr_addr_s1 <= sweep_cnt_q;
			wr_data_s1 <= {sweep_attr, CH_SPACE};
			wr_copy_s1 <= sweep_rd;
		end else if (cmd.accept) begin
			wr_addr_s1 <= cur_loc;
			wr_data_s1 <= {attr_q, char_code};
			wr_copy_s1 <= 1'b0;
		end
	end

	// Cell buffer: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_pend_s1) begin
			cells_q[wr_addr_s1] <= wr_copy_s1 ? rd_data_q : wr_data_s1;
		end
		if (rd_en) begin
			rd_data_q <= cells_q[rd_addr];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_col_q  <= OCOL_W'(cur_col_q);
			out_row_q  <= OROW_W'(cur_row_q);
			out_loc_q  <= OLOC_W'(cur_loc);
			out_cell_q <= cell_sel_q ? rd_data_q : '0;
			out_scr_q  <= scrolled_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign cursor_col  = out_col_q;
	assign cursor_row  = out_row_q;
	assign cursor_addr = out_loc_q;
	assign cell_data   = out_cell_q;
	assign scrolled    = out_scr_q;

endmodule : tccs_dp
`default_nettype wire

### sv/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
`default_nettype none
// Put character, read cell and no-op: the accepted command moves the sequencer to its
//   respond state, which loads the result register; the next command is taken only after that.
// Clear and scroll sweep the cell buffer one cell a cycle over its single write
//   port, with input held off until the result is loaded.
// Reset: cursor homed, attribute 0x0F; a clearing pass then blanks every cell
//   while s_tready stays low. cfg writes always taken.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: text console engine
// Cell buffer with cursor, line wrap and scroll; takes put-character,
// clear-screen and read-cell commands and returns one result for each.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
	import tccs_pkg::*;
#(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// command stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // char_code[7:0], cell_index[18:8], zeros
	input  wire logic [OPC_W-1:0]    s_tuser,  // opcode[1:0]
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // cursor_col[6:0], cursor_row[11:7],
	                                           // cursor_addr[22:12],
	                                           // cell_data[38:23], scrolled[39]
	// attribute register write
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [ATTR_W-1:0]   cfg_data
);

	cmd_t cmd;
	sts_t sts;

	logic [OCOL_W-1:0] cursor_col;
	logic [OROW_W-1:0] cursor_row;
	logic [OLOC_W-1:0] cursor_addr;
	logic [CELL_W-1:0] cell_data;
	logic              scrolled;

	assign cfg_ready = 1'b1;

	tccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tccs_dp #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (s_tuser),
		.char_code   (s_tdata[CHAR_W-1:0]),
		.cell_index  (s_tdata[CHAR_W+IDX_W-1:CHAR_W]),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.cursor_col  (cursor_col),
		.cursor_row  (cursor_row),
		.cursor_addr (cursor_addr),
		.cell_data   (cell_data),
		.scrolled    (scrolled)
	);

	// Pack the result fields, lowest first
	assign m_tdata = {scrolled, cell_data, cursor_addr, cursor_row, cursor_col};

endmodule : text_console_cursor_scroll
`default_nettype wire

### sv/tccs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_checker: port-level checks for the text console engine
// Watches command and result transfers; bound to the top level below.
// ----------------------------------------------------------------------------
module tccs_checker
	import tccs_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata
);

	logic in_xfer, out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// Commands taken whose results are not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	logic [OCOL_W-1:0] col_f;
	logic [OROW_W-1:0] row_f;
	logic              scr_f;
	assign col_f = m_tdata[M_COL_LSB +: OCOL_W];
	assign row_f = m_tdata[M_ROW_LSB +: OROW_W];
	assign scr_f = m_tdata[M_SCR_BIT];

	// One command in the engine at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("command transfer while previous still executing");

	// No result without a command behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pend_q != 2'd0))
		else $error("result offered with no command outstanding");

	// Never more than one executing plus one waiting result
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("too many commands outstanding");

	// Cursor column stays on screen
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(col_f) < COLUMNS))
		else $error("cursor column off screen");

	// A scroll leaves the cursor on the bottom row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && scr_f) |-> (row_f == OROW_W'(ROWS - 1)))
		else $error("scroll did not leave cursor on bottom row");

endmodule : tccs_checker

bind text_console_cursor_scroll tccs_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tccs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

### tb/text_console_cursor_scroll_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_test: self-checking bench for the text console
// Drives put-character, clear, read-cell and unused commands over the command
// stream and keeps a cycle-free model of the cell buffer and cursor. Every
// result transfer is checked field by field against the oldest prediction.
// Both streams idle at random; the attribute is rewritten between phases.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_test;
	import tccs_pkg::*;

	localparam int COLUMNS        = 80;
	localparam int ROWS           = 25;
	localparam int TAB_STOP       = 8;
	localparam int CELL_COUNT     = ROWS * COLUMNS;
	localparam int IDX_MAX        = (1 << IDX_W) - 1;
	localparam logic [OPC_W-1:0] OP_NONE = 2'd3;
	// a clear or scroll sweep must fit well inside this limit with no transfer
	localparam int WATCHDOG_LIMIT = 25000;
	localparam int END_WAIT       = 64;

	typedef struct {
		logic [OCOL_W-1:0] col;
		logic [OROW_W-1:0] row;
		logic [OLOC_W-1:0] loc;
		logic [CELL_W-1:0] cell_word;
		logic              scrolled;
	} console_status_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [OPC_W-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [ATTR_W-1:0]   cfg_data;

	// console model
	logic [CELL_W-1:0] screen_model [CELL_COUNT];
	int unsigned       cursor_col_m;
	int unsigned       cursor_row_m;
	logic [ATTR_W-1:0] text_attr_m;

	console_status_t   status_queue [$];
	int unsigned       error_count = 0;
	int unsigned       burst_left = 0;
	int unsigned       idle_cycles = 0;
	int unsigned       stall_tick = 0;
	int unsigned       stall_mode = 0;

	text_console_cursor_scroll #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted command to the model and queue the status it gives
	task automatic console_apply(input logic [OPC_W-1:0] op, input logic [CHAR_W-1:0] ch,
	                             input logic [IDX_W-1:0] idx);
		console_status_t st;
		st.cell_word = '0;
		st.scrolled = 1'b0;
		case (op)
			OP_PUT: begin
				if (ch == CH_BS) begin
					if (cursor_col_m > 0)
						cursor_col_m--;
				end else if (ch == CH_TAB) begin
					cursor_col_m = cursor_col_m + TAB_STOP - (cursor_col_m % TAB_STOP);
				end else if (ch == CH_CR) begin
					cursor_col_m = 0;
				end else if (ch == CH_LF) begin
					cursor_col_m = 0;
					cursor_row_m++;
				end else if (ch >= CH_SPACE && ch <= CH_DEL) begin
					screen_model[cursor_row_m * COLUMNS + cursor_col_m] = {text_attr_m, ch};
					cursor_col_m++;
				end
				// line wrap
				if (cursor_col_m >= COLUMNS) begin
					cursor_col_m = 0;
					cursor_row_m++;
				end
				// scroll up one line, blank the bottom one
				if (cursor_row_m >= ROWS) begin
					for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
						screen_model[i] = screen_model[i + COLUMNS];
					for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
						screen_model[i] = {text_attr_m, CH_SPACE};
					cursor_row_m = ROWS - 1;
					st.scrolled = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen_model[i] = {text_attr_m, CH_SPACE};
				cursor_col_m = 0;
				cursor_row_m = 0;
			end
			OP_READ: begin
				if (idx < CELL_COUNT)
					st.cell_word = screen_model[idx];
			end
			default: ;
		endcase
		st.col = cursor_col_m[OCOL_W-1:0];
		st.row = cursor_row_m[OROW_W-1:0];
		st.loc = OLOC_W'(cursor_row_m * COLUMNS + cursor_col_m);
		status_queue.push_back(st);
	endtask

	// Offer one command, idling between bursts, and record it once transferred
	task automatic send_command(input logic [OPC_W-1:0] op, input logic [CHAR_W-1:0] ch,
	                            input logic [IDX_W-1:0] idx);
		int unsigned gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 2);
				default: gap = $urandom_range(1, 12);
			endcase
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_DATA_W - CHAR_W - IDX_W){1'b0}}, idx, ch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		console_apply(op, ch, idx);
	endtask

	// Hold the command stream until every predicted result has arrived
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (status_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_attribute(input logic [ATTR_W-1:0] value);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		text_attr_m = value;
	endtask

	// Buffer after the power-up clearing pass, including reads out of range
	task automatic test_reset_contents();
		send_command(OP_READ, 8'h00, 11'd0);
		send_command(OP_READ, 8'hFF, 11'(CELL_COUNT - 1));
		send_command(OP_READ, 8'h00, 11'(CELL_COUNT));
		send_command(OP_READ, 8'hFF, 11'(IDX_MAX));
	endtask

	// Printable extremes, ignored bytes, each control byte, no-op and clear
	task automatic test_control_bytes();
		send_command(OP_PUT, 8'h41, 11'd0);
		send_command(OP_PUT, CH_SPACE, 11'(IDX_MAX));
		send_command(OP_PUT, CH_DEL, 11'd0);
		send_command(OP_PUT, 8'h1F, 11'd0);
		send_command(OP_PUT, 8'h00, 11'd0);
		send_command(OP_PUT, 8'h80, 11'd0);
		send_command(OP_PUT, 8'hFF, 11'd0);
		send_command(OP_PUT, CH_BS, 11'd0);
		send_command(OP_PUT, CH_CR, 11'd0);
		// backspace at column zero stays put
		send_command(OP_PUT, CH_BS, 11'd0);
		send_command(OP_PUT, CH_TAB, 11'd0);
		send_command(OP_PUT, 8'h78, 11'd0);
		send_command(OP_PUT, CH_TAB, 11'd0);
		send_command(OP_PUT, CH_LF, 11'd0);
		send_command(OP_READ, 8'h00, 11'd0);
		send_command(OP_READ, 8'h00, 11'd2);
		send_command(OP_READ, 8'h00, 11'd8);
		send_command(OP_NONE, 8'hFF, 11'(IDX_MAX));
		send_command(OP_CLEAR, 8'hFF, 11'(IDX_MAX));
		send_command(OP_READ, 8'h00, 11'd0);
	endtask

	// Mostly text lines with wrap and scroll; reads, cursor moves and noise mixed in
	task automatic test_console_traffic(input int unsigned item_target);
		int unsigned counted = 0;
		int unsigned len;
		int unsigned kind;
		int          loc;
		while (counted < item_target) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				len = $urandom_range(1, 100);
				repeat (len)
					send_command(OP_PUT, 8'($urandom_range(CH_SPACE, CH_DEL)),
					             11'($urandom_range(0, IDX_MAX)));
				counted += len;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						send_command(OP_PUT, CH_CR, 11'($urandom_range(0, IDX_MAX)));
						send_command(OP_PUT, CH_LF, 11'($urandom_range(0, IDX_MAX)));
						counted += 2;
					end
					5, 6, 7: begin
						send_command(OP_PUT, CH_LF, 11'($urandom_range(0, IDX_MAX)));
						counted++;
					end
					default: ;
				endcase
			end else if (kind < 60) begin
				len = $urandom_range(1, 4);
				repeat (len) begin
					case ($urandom_range(0, 19))
						0, 1, 2: loc = $urandom_range(0, IDX_MAX);
						3, 4, 5: begin
							loc = int'(cursor_row_m * COLUMNS + cursor_col_m)
							      - int'($urandom_range(0, COLUMNS));
							if (loc < 0)
								loc = 0;
						end
						default: loc = $urandom_range(0, CELL_COUNT - 1);
					endcase
					send_command(OP_READ, 8'($urandom_range(0, 255)), 11'(loc));
				end
				counted += len;
			end else if (kind < 70) begin
				// arbitrary bytes, mostly ignored by the block
				repeat ($urandom_range(1, 3))
					send_command(OP_PUT, 8'($urandom_range(0, 255)),
					             11'($urandom_range(0, IDX_MAX)));
			end else if (kind < 80) begin
				len = $urandom_range(1, 12);
				repeat (len) begin
					case ($urandom_range(0, 2))
						0: send_command(OP_PUT, CH_BS, 11'($urandom_range(0, IDX_MAX)));
						1: send_command(OP_PUT, CH_TAB, 11'($urandom_range(0, IDX_MAX)));
						default: send_command(OP_PUT, CH_CR,
						                      11'($urandom_range(0, IDX_MAX)));
					endcase
				end
				counted += len;
			end else if (kind < 90) begin
				len = $urandom_range(1, 6);
				repeat (len)
					send_command(OP_PUT, CH_LF, 11'($urandom_range(0, IDX_MAX)));
				counted += len;
			end else if (kind < 94) begin
				send_command(OP_NONE, 8'($urandom_range(0, 255)),
				             11'($urandom_range(0, IDX_MAX)));
			end else if (kind < 96) begin
				send_command(OP_CLEAR, 8'($urandom_range(0, 255)),
				             11'($urandom_range(0, IDX_MAX)));
				counted++;
			end else begin
				wait_drained();
			end
		end
	endtask

	// Receiver stall pattern, switching between randomly chosen modes
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 256 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (stall_tick % 5 != 2) && (stall_tick % 13 < 9);
			default: m_tready <= stall_tick[3];
		endcase
	end

	// Result checker
	always @(posedge clk) begin
		console_status_t st;
		if (arst_n && m_tvalid && m_tready) begin
			if (status_queue.size() == 0) begin
				$error("result transfer with no command outstanding");
				error_count++;
			end else begin
				st = status_queue.pop_front();
				if (m_tdata[M_COL_LSB +: OCOL_W] !== st.col) begin
					$error("cursor_col: expected %0d, got %0d", st.col,
					       m_tdata[M_COL_LSB +: OCOL_W]);
					error_count++;
				end
				if (m_tdata[M_ROW_LSB +: OROW_W] !== st.row) begin
					$error("cursor_row: expected %0d, got %0d", st.row,
					       m_tdata[M_ROW_LSB +: OROW_W]);
					error_count++;
				end
				if (m_tdata[M_LOC_LSB +: OLOC_W] !== st.loc) begin
					$error("cursor_addr: expected %0d, got %0d", st.loc,
					       m_tdata[M_LOC_LSB +: OLOC_W]);
					error_count++;
				end
				if (m_tdata[M_CELL_LSB +: CELL_W] !== st.cell_word) begin
					$error("cell_data: expected %04h, got %04h", st.cell_word,
					       m_tdata[M_CELL_LSB +: CELL_W]);
					error_count++;
				end
				if (m_tdata[M_SCR_BIT] !== st.scrolled) begin
					$error("scrolled: expected %0d, got %0d", st.scrolled, m_tdata[M_SCR_BIT]);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_PUT;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		for (int i = 0; i < CELL_COUNT; i++)
			screen_model[i] = {RESET_ATTR, CH_SPACE};
		cursor_col_m = 0;
		cursor_row_m = 0;
		text_attr_m  = RESET_ATTR;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_control_bytes();
		set_attribute(8'h00);
		test_console_traffic(300);
		set_attribute(8'hFF);
		test_console_traffic(300);
		set_attribute(8'($urandom_range(0, 255)));
		test_console_traffic(330);

		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		if (status_queue.size() != 0) begin
			$error("%0d results never arrived", status_queue.size());
			error_count++;
		end
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
